// ===== hw/rtl/pvp_pkg.sv =====
// ----------------------------------------------------------------------------
// Pinhole vertex projection package
// Shared constants, codes and types for the projection block.
// ----------------------------------------------------------------------------
package pvp_pkg;

	localparam int NUM_COEFS   = 13;
	localparam int COEF_W      = 32;
	localparam int COEF_TRANS  = 9;
	localparam int COEF_FOCAL  = 12;
	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 64;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int LEVEL_W     = 3;
	// Transformed coordinates fit in 35 bits; one spare bit.
	localparam int WSUM_W      = 36;
	localparam int NUM_A_W     = WSUM_W + 16;
	localparam int M_W         = 50;
	localparam int NUM_B_W     = M_W + 17;

	typedef enum logic {
		KIND_LOAD    = 1'b0,
		KIND_PROJECT = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_W = 1'b0,
		CFG_FRAME_H = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_COEFS-1:0][COEF_W-1:0] coef;
		logic [2:0][31:0]                 vtx;
	} queue_entry_t;

	typedef struct packed {
		logic               vld;
		logic [LEVEL_W-1:0] level;
	} queue_stat_t;

endpackage

// ===== hw/rtl/pvp_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage, with sign and 32-bit clip.
// ----------------------------------------------------------------------------
module pvp_div #(
	parameter int NW = 52,
	parameter int DW = 36,
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  logic [NW-1:0]       num,
	input  logic [DW-1:0]       den,
	input  logic                neg,
	input  logic [SW-1:0]       side_in,
	output logic                vld_out,
	output logic signed [31:0]  quo,
	output logic                sat,
	output logic [SW-1:0]       side_out
);
	localparam int QW  = 32;
	localparam int CW  = (NW > DW + QW) ? NW : DW + QW;
	localparam int NST = QW + 1;

	logic [NW-1:0] rem_q  [NST];
	logic [QW-1:0] quo_q  [NST];
	logic [DW-1:0] den_q  [NST];
	logic          ovf_q  [NST];
	logic          neg_q  [NST];
	logic [SW-1:0] side_q [NST];
	logic          vld_q  [NST];
	logic [QW-1:0] q_last;
	logic          sat_d;
	logic [31:0]   res_d;

	// The first stage flags quotients of 2^32 and above; they always clip.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= num;
			quo_q[0]  <= '0;
			den_q[0]  <= den;
			ovf_q[0]  <= CW'(num) >= (CW'(den) << QW);
			neg_q[0]  <= neg;
			side_q[0] <= side_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= vld_in;
		end
	end

	for (genvar j = 1; j < NST; j++) begin : g_stage
		localparam int K = QW - j;
		logic          ge;
		logic [CW-1:0] sub;
		logic [QW-1:0] qn;

		assign ge  = CW'(rem_q[j-1]) >= (CW'(den_q[j-1]) << K);
		assign sub = CW'(rem_q[j-1]) - (CW'(den_q[j-1]) << K);
		assign qn  = quo_q[j-1] | (QW'(ge) << K);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j]  <= ge ? sub[NW-1:0] : rem_q[j-1];
				quo_q[j]  <= qn;
				den_q[j]  <= den_q[j-1];
				ovf_q[j]  <= ovf_q[j-1];
				neg_q[j]  <= neg_q[j-1];
				side_q[j] <= side_q[j-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (en) begin
				vld_q[j] <= vld_q[j-1];
			end
		end
	end

	assign q_last = quo_q[NST-1];

	// A negative result of magnitude 2^31 is still representable.
	always_comb begin
		if (neg_q[NST-1]) begin
			sat_d = ovf_q[NST-1] || (q_last[31] && (q_last[30:0] != '0));
			res_d = sat_d ? 32'h8000_0000 : (32'h0 - q_last);
		end else begin
			sat_d = ovf_q[NST-1] || q_last[31];
			res_d = sat_d ? 32'h7fff_ffff : q_last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo      <= $signed(res_d);
			sat      <= sat_d;
			side_out <= side_q[NST-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_q[NST-1];
		end
	end

endmodule

// ===== hw/rtl/pvp_queue.sv =====
// ----------------------------------------------------------------------------
// Projection queue
// Short queue that carries fetched camera data from the front to the back.
// ----------------------------------------------------------------------------
module pvp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pvp_pkg::queue_entry_t push_data,
	input  logic                  pop,
	output pvp_pkg::queue_entry_t pop_data,
	output pvp_pkg::queue_stat_t  stat
);
	import pvp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	queue_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LEVEL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			level_q <= level_q + LEVEL_W'(push) - LEVEL_W'(pop);
		end
	end

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.vld   = level_q != '0;
	assign stat.level = level_q;

endmodule

// ===== hw/rtl/pvp_front.sv =====
// ----------------------------------------------------------------------------
// Projection front end
// Accepts transactions, writes camera coefficients and fetches camera entries.
// ----------------------------------------------------------------------------
module pvp_front #(
	parameter int MAX_CAMERAS = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pvp_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                               s_tuser,
	input  pvp_pkg::queue_stat_t               stat,
	output logic                               push,
	output pvp_pkg::queue_entry_t              push_data
);
	import pvp_pkg::*;

	localparam int AW = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;

	logic              accept;
	logic [7:0]        cam;
	logic [3:0]        coef_idx;
	logic [31:0]       coef_val;
	logic [AW+7:0]     cam_ext;
	logic [AW-1:0]     addr;
	logic              oob;
	logic              wr_en;
	logic              rd_en;
	logic [31:0]       rd_q [NUM_COEFS];
	logic              vld_s1;
	logic              oob_s1;
	logic [2:0][31:0]  vtx_s1;

	assign cam      = s_tdata[7:0];
	assign coef_idx = s_tdata[11:8];
	assign coef_val = s_tdata[43:12];
	assign cam_ext  = {AW'(0), cam};
	assign addr     = cam_ext[AW-1:0];
	assign oob      = cam_ext >= (AW+8)'(MAX_CAMERAS);

	// Credit covers the entry still being fetched.
	assign s_tready = ((LEVEL_W+1)'(stat.level) + (LEVEL_W+1)'(vld_s1))
	                  < (LEVEL_W+1)'(QUEUE_DEPTH);
	assign accept   = s_tvalid && s_tready;
	assign wr_en    = accept && (s_tuser == KIND_LOAD) && !oob
	                  && (coef_idx < 4'(NUM_COEFS));
	assign rd_en    = accept && (s_tuser == KIND_PROJECT);

	for (genvar b = 0; b < NUM_COEFS; b++) begin : g_bank
		logic [31:0] mem [MAX_CAMERAS];

		always_ff @(posedge clk) begin
			if (wr_en && (coef_idx == 4'(b))) begin
				mem[addr] <= coef_val;
			end
			if (rd_en) begin
				rd_q[b] <= mem[addr];
			end
		end

		assign push_data.coef[b] = oob_s1 ? 32'h0 : rd_q[b];
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			oob_s1    <= oob;
			vtx_s1[0] <= s_tdata[75:44];
			vtx_s1[1] <= s_tdata[107:76];
			vtx_s1[2] <= s_tdata[139:108];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
		end
	end

	assign push          = vld_s1;
	assign push_data.vtx = vtx_s1;

endmodule

// ===== hw/rtl/pvp_back.sv =====
// ----------------------------------------------------------------------------
// Projection back end
// Transforms the vertex, divides by depth and maps to texture coordinates.
// ----------------------------------------------------------------------------
module pvp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pvp_pkg::queue_stat_t  stat,
	input  pvp_pkg::queue_entry_t pop_data,
	output logic                  pop,
	input  logic [15:0]           frame_w,
	input  logic [15:0]           frame_h,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic signed [31:0]    tex_u,
	output logic signed [31:0]    tex_v,
	output logic                  zero_depth,
	output logic                  saturated
);
	import pvp_pkg::*;

	logic                      en;
	logic                      vld_s1;
	logic signed [63:0]        p_s1 [9];
	logic signed [31:0]        t_s1 [3];
	logic [31:0]               f_s1;
	logic signed [WSUM_W-1:0]  w_d  [3];
	logic                      vld_s2;
	logic signed [WSUM_W-1:0]  w_s2 [3];
	logic [31:0]               f_s2;
	logic [WSUM_W-1:0]         ax, ay, az;
	logic                      vld_s3;
	logic [NUM_A_W-1:0]        numx_s3, numy_s3;
	logic [WSUM_W-1:0]         den_s3;
	logic                      negx_s3, negy_s3, zero_s3;
	logic [31:0]               f_s3;
	logic                      vld_xa, vld_ya;
	logic signed [31:0]        rx, ry;
	logic                      satx, saty;
	logic [31:0]               f_a;
	logic                      zero_a;
	logic                      vld_s4;
	logic signed [63:0]        px_s4, py_s4;
	logic                      sat_s4, zero_s4;
	logic [15:0]               s_u, s_v;
	logic signed [63:0]        hx, hy;
	logic                      vld_s5;
	logic signed [M_W-1:0]     mx_s5, my_s5;
	logic                      sat_s5, zero_s5;
	logic [M_W-1:0]            amx, amy;
	logic                      vld_s6;
	logic [NUM_B_W-1:0]        numu_s6, numv_s6;
	logic                      negu_s6, negv_s6, sat_s6, zero_s6;
	logic                      vld_ub, vld_vb;
	logic signed [31:0]        qu, qv;
	logic                      satu, satv, sat_b, zero_b;

	// The whole back end moves together; it halts only on a held result.
	assign en  = !m_tvalid || m_tready;
	assign pop = en && stat.vld;

	assign s_u = (frame_w == '0) ? 16'd1 : frame_w;
	assign s_v = (frame_h == '0) ? 16'd1 : frame_h;

	// Stage 1: rotation products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s1[i*3+j] <= $signed(pop_data.coef[i*3+j]) * $signed(pop_data.vtx[j]);
				end
				t_s1[i] <= $signed(pop_data.coef[COEF_TRANS+i]);
			end
			f_s1 <= pop_data.coef[COEF_FOCAL];
		end
	end

	// Stage 2: round each product to Q16.16 and add the translation.
	always_comb begin
		logic signed [63:0]       rnd;
		logic signed [WSUM_W-1:0] acc;
		for (int i = 0; i < 3; i++) begin
			acc = WSUM_W'(t_s1[i]);
			for (int j = 0; j < 3; j++) begin
				rnd = (p_s1[i*3+j] + 64'sd536870912) >>> 30;
				acc = acc + WSUM_W'(rnd);
			end
			w_d[i] = acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2 <= w_d;
			f_s2 <= f_s1;
		end
	end

	// Stage 3: magnitudes and rounding offset for the depth division.
	assign ax = w_s2[0][WSUM_W-1] ? WSUM_W'(-w_s2[0]) : WSUM_W'(w_s2[0]);
	assign ay = w_s2[1][WSUM_W-1] ? WSUM_W'(-w_s2[1]) : WSUM_W'(w_s2[1]);
	assign az = w_s2[2][WSUM_W-1] ? WSUM_W'(-w_s2[2]) : WSUM_W'(w_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s3 <= {ax, 16'h0} + NUM_A_W'(az >> 1);
			numy_s3 <= {ay, 16'h0} + NUM_A_W'(az >> 1);
			den_s3  <= az;
			// The numerator is the negated coordinate.
			negx_s3 <= (!w_s2[0][WSUM_W-1] && (w_s2[0] != '0)) ^ w_s2[2][WSUM_W-1];
			negy_s3 <= (!w_s2[1][WSUM_W-1] && (w_s2[1] != '0)) ^ w_s2[2][WSUM_W-1];
			zero_s3 <= w_s2[2] == '0;
			f_s3    <= f_s2;
		end
	end

	pvp_div #(.NW(NUM_A_W), .DW(WSUM_W), .SW(32)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s3),
		.num(numx_s3), .den(den_s3), .neg(negx_s3), .side_in(f_s3),
		.vld_out(vld_xa), .quo(rx), .sat(satx), .side_out(f_a)
	);

	pvp_div #(.NW(NUM_A_W), .DW(WSUM_W), .SW(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s3),
		.num(numy_s3), .den(den_s3), .neg(negy_s3), .side_in(zero_s3),
		.vld_out(vld_ya), .quo(ry), .sat(saty), .side_out(zero_a)
	);

	// Stage 4: scale by the focal length.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s4   <= rx * $signed(f_a);
			py_s4   <= ry * $signed(f_a);
			sat_s4  <= satx || saty;
			zero_s4 <= zero_a;
		end
	end

	// Stage 5: round to Q16.16 and add the image center.
	assign hx = (px_s4 + 64'sd32768) >>> 16;
	assign hy = (py_s4 + 64'sd32768) >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s5   <= M_W'(hx) + M_W'({s_u, 15'h0});
			my_s5   <= M_W'(hy) + M_W'({s_v, 15'h0});
			sat_s5  <= sat_s4;
			zero_s5 <= zero_s4;
		end
	end

	// Stage 6: magnitudes and rounding offset for the size division.
	assign amx = mx_s5[M_W-1] ? M_W'(-mx_s5) : M_W'(mx_s5);
	assign amy = my_s5[M_W-1] ? M_W'(-my_s5) : M_W'(my_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			numu_s6 <= NUM_B_W'({amx, 16'h0}) + NUM_B_W'(s_u >> 1);
			numv_s6 <= NUM_B_W'({amy, 16'h0}) + NUM_B_W'(s_v >> 1);
			negu_s6 <= mx_s5[M_W-1];
			negv_s6 <= my_s5[M_W-1];
			sat_s6  <= sat_s5;
			zero_s6 <= zero_s5;
		end
	end

	pvp_div #(.NW(NUM_B_W), .DW(16), .SW(1)) u_div_u (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s6),
		.num(numu_s6), .den(s_u), .neg(negu_s6), .side_in(sat_s6),
		.vld_out(vld_ub), .quo(qu), .sat(satu), .side_out(sat_b)
	);

	pvp_div #(.NW(NUM_B_W), .DW(16), .SW(1)) u_div_v (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s6),
		.num(numv_s6), .den(s_v), .neg(negv_s6), .side_in(zero_s6),
		.vld_out(vld_vb), .quo(qv), .sat(satv), .side_out(zero_b)
	);

	// Output register; a zero depth overrides everything computed after it.
	always_ff @(posedge clk) begin
		if (en) begin
			tex_u      <= zero_b ? 32'sh0 : qu;
			tex_v      <= zero_b ? 32'sh0 : qv;
			zero_depth <= zero_b;
			saturated  <= !zero_b && (sat_b || satu || satv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			vld_s6   <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_s1   <= stat.vld;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_xa && vld_ya;
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			m_tvalid <= vld_ub && vld_vb;
		end
	end

endmodule

// ===== hw/rtl/pinhole_vertex_projection.sv =====
// Pinhole vertex projection: takes one transaction per clock while s_tready is
// high, either a camera coefficient load or a vertex to project, and returns
// one texture coordinate transaction per projected vertex, in order. Loads
// give no result and are visible to a projection taken in the next cycle.
// Sustained throughput is one transaction per cycle when the output is not
// stalled. The four pipelined restoring dividers (two for the depth, two for
// the image size) are each 34 stages deep: an overflow check, one per quotient
// bit and an output register. A four-entry queue behind the camera table
// fetch lets input keep flowing while a finished result waits on the output.
// The camera table holds MAX_CAMERAS entries of 13 coefficients and has no reset.

// ----------------------------------------------------------------------------
// Pinhole vertex projection
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
module pinhole_vertex_projection #(
	parameter int MAX_CAMERAS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// camera_index, coef_index, coef_value, vertex_x, vertex_y, vertex_z
	input  logic [pvp_pkg::IN_TDATA_W-1:0]   s_tdata,
	// kind
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tex_u, tex_v
	output logic [pvp_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// zero_depth, saturated
	output logic [1:0]                       m_tuser,
	input  logic                             cfg_we,
	input  logic [pvp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pvp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pvp_pkg::*;

	logic [15:0]         frame_w_q;
	logic [15:0]         frame_h_q;
	queue_stat_t         stat;
	logic                push;
	queue_entry_t        push_data;
	logic                pop;
	queue_entry_t        pop_data;
	logic signed [31:0]  tex_u;
	logic signed [31:0]  tex_v;
	logic                zero_depth;
	logic                saturated;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= 16'd640;
			frame_h_q <= 16'd480;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FRAME_W: frame_w_q <= cfg_data;
				CFG_FRAME_H: frame_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pvp_front #(.MAX_CAMERAS(MAX_CAMERAS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.stat(stat), .push(push), .push_data(push_data)
	);

	pvp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data),
		.pop(pop), .pop_data(pop_data), .stat(stat)
	);

	pvp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.stat(stat), .pop_data(pop_data), .pop(pop),
		.frame_w(frame_w_q), .frame_h(frame_h_q),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.tex_u(tex_u), .tex_v(tex_v),
		.zero_depth(zero_depth), .saturated(saturated)
	);

	assign m_tdata = {tex_v, tex_u};
	assign m_tuser = {saturated, zero_depth};

endmodule

// ===== hw/rtl/pvp_checker.sv =====
// ----------------------------------------------------------------------------
// Projection port checker
// Checks on the output stream of the projection block, bound to the top level.
// ----------------------------------------------------------------------------
module pvp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A result held by the sink must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output transaction changed while stalled");

	// A zero depth result carries zero coordinates and no clip flag.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 64'h0) && !m_tuser[1])
		else $error("zero depth result with nonzero payload");

	// Nothing leaves the block while it is held in reset.
	a_rst: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind pinhole_vertex_projection pvp_checker u_pvp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);
